/* rtl/swarq_pkg.sv */
// ----------------------------------------------------------------------------
// swarq_pkg: shared types and constants of the sliding-window ARQ endpoint
// Request and result payloads, request and result codes, sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package swarq_pkg;

  localparam int unsigned WindowSlotsDef = 16;

  localparam int unsigned SeqW    = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned LenW    = 16;
  localparam int unsigned CountW  = 5;

  // Request type codes.
  localparam logic [1:0] REQ_DATA = 2'd0;
  localparam logic [1:0] REQ_ACK  = 2'd1;
  localparam logic [1:0] REQ_SENT = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SeqW-1:0]    seq;
    logic [HandleW-1:0] payload_handle;
    logic [LenW-1:0]    payload_len;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [HandleW-1:0] deliver_handle;
    logic [LenW-1:0]    deliver_len;
    logic [SeqW-1:0]    ack_seq;
    logic               accepted;
    logic [CountW-1:0]  freed_count;
    logic [CountW-1:0]  outstanding_count;
    logic               window_full;
    logic               closing;
    logic               last;
  } out_rsp_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [LenW-1:0]    len;
  } slot_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_EVAL,
    ST_DRAIN,
    ST_ACK,
    ST_CLOSE_ACK,
    ST_STATUS
  } state_e;

endpackage

`default_nettype wire

/* rtl/swarq_slot_store.sv */
// ----------------------------------------------------------------------------
// swarq_slot_store: receive window slot storage
// Valid-marked slots holding handle and length of frames waiting for delivery.
// ----------------------------------------------------------------------------
`default_nettype none

module swarq_slot_store #(
  parameter int unsigned WindowSlots = swarq_pkg::WindowSlotsDef,
  parameter int unsigned IdxW        = $clog2(WindowSlots)
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      wr_en_i,
  input  wire  [IdxW-1:0]          wr_idx_i,
  input  wire  swarq_pkg::slot_data_t wr_data_i,
  input  wire                      clr_en_i,
  input  wire  [IdxW-1:0]          rd_idx_i,
  output logic                     rd_valid_o,
  output swarq_pkg::slot_data_t    rd_data_o
);
  import swarq_pkg::*;

  logic [WindowSlots-1:0] valid_q;
  slot_data_t             data_q [WindowSlots];

  // The clear always targets the slot being read (the receive head).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (clr_en_i) begin
        valid_q[rd_idx_i] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_data_o  = data_q[rd_idx_i];

endmodule

`default_nettype wire

/* rtl/sliding_window_arq_endpoint.sv */
// ----------------------------------------------------------------------------
// sliding_window_arq_endpoint: selective-repeat ARQ receive and send window
// Stores in-window data frames, drains them in order with a cumulative ack,
// and tracks outstanding send frames from ack and frame-sent requests.
// ----------------------------------------------------------------------------
// Sequencing: a request is captured in IDLE, offset from its window base in
// DIFF and applied in EVAL; a data request then delivers frames in DRAIN and
// acks in ACK and CLOSE_ACK, others report in STATUS; output stalls hold each.
// One request in flight: the next is accepted once the last result of the
// previous one is registered; an ignored request type goes back from DIFF.
// Reset (rst_ni low, asynchronous) clears slot valid bits and all window state.
`default_nettype none

module sliding_window_arq_endpoint #(
  parameter int unsigned WindowSlots = swarq_pkg::WindowSlotsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire  swarq_pkg::in_req_t  in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output swarq_pkg::out_rsp_t   out_rsp_o
);
  import swarq_pkg::*;

  localparam int unsigned IdxW = $clog2(WindowSlots);
  localparam int unsigned CntW = $clog2(WindowSlots + 1);
  localparam logic [SeqW-1:0] WinSeq  = SeqW'(WindowSlots);
  localparam logic [IdxW:0]   WinIdx  = (IdxW+1)'(WindowSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(WindowSlots - 1);
  localparam logic [CntW-1:0] WinCnt  = CntW'(WindowSlots);

  // Sequencer and the captured request.
  state_e            state_q, state_d;
  in_req_t           req_q;
  logic [SeqW-1:0]   diff_q, diff_d;
  logic              acc_q, acc_d;
  logic [CntW-1:0]   freed_q, freed_d;
  logic              full_q, full_d;

  // Architectural window state.
  logic [SeqW-1:0]   expected_q, expected_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic [SeqW-1:0]   tx_base_q, tx_base_d;
  logic [CntW-1:0]   outst_q, outst_d;
  logic              closed_q, closed_d;

  // Result register, which decouples the sequencer from the consumer.
  logic              out_valid_q;
  out_rsp_t          out_q;
  logic              emit;
  out_rsp_t          rsp;
  logic              out_free;

  // Shared adder: every sequence-number add or subtract goes through it.
  logic [SeqW-1:0]   alu_a, alu_b, alu_res;
  logic              alu_sub;

  // Slot store interface.
  logic              slot_wr_en;
  logic [IdxW-1:0]   slot_wr_idx;
  slot_data_t        slot_wr_data;
  logic              slot_clr_en;
  logic              slot_rd_valid;
  slot_data_t        slot_rd_data;

  // Helpers derived from the registered difference and the captured request.
  logic              in_win;
  logic [IdxW:0]     idx_sum;
  logic [CntW-1:0]   diff_p1;
  logic [CntW-1:0]   freed_calc;
  logic              len_zero;

  assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

  assign in_win   = (diff_q < WinSeq);
  assign len_zero = (req_q.payload_len == '0);
  assign out_free = !out_valid_q || out_ready_i;

  // Slot index sum of an in-window frame, wrapped modulo the window size below.
  assign idx_sum = {1'b0, head_q} + {1'b0, diff_q[IdxW-1:0]};

  // An in-window ack frees difference plus one frames, limited to what is
  // outstanding.
  assign diff_p1    = CntW'(diff_q) + CntW'(1);
  assign freed_calc = (diff_p1 > outst_q) ? outst_q : diff_p1;

  assign slot_wr_data.handle = req_q.payload_handle;
  assign slot_wr_data.len    = req_q.payload_len;

  swarq_slot_store #(
    .WindowSlots (WindowSlots),
    .IdxW        (IdxW)
  ) u_slots (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (slot_wr_en),
    .wr_idx_i   (slot_wr_idx),
    .wr_data_i  (slot_wr_data),
    .clr_en_i   (slot_clr_en),
    .rd_idx_i   (head_q),
    .rd_valid_o (slot_rd_valid),
    .rd_data_o  (slot_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      expected_q  <= '0;
      head_q      <= '0;
      tx_base_q   <= '0;
      outst_q     <= '0;
      closed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      expected_q <= expected_d;
      head_q     <= head_d;
      tx_base_q  <= tx_base_d;
      outst_q    <= outst_d;
      closed_q   <= closed_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= in_req_i;
    end
    diff_q  <= diff_d;
    acc_q   <= acc_d;
    freed_q <= freed_d;
    full_q  <= full_d;
    if (emit) begin
      out_q <= rsp;
    end
  end

  always_comb begin
    state_d     = state_q;
    diff_d      = diff_q;
    acc_d       = acc_q;
    freed_d     = freed_q;
    full_d      = full_q;
    expected_d  = expected_q;
    head_d      = head_q;
    tx_base_d   = tx_base_q;
    outst_d     = outst_q;
    closed_d    = closed_q;
    alu_a       = req_q.seq;
    alu_b       = expected_q;
    alu_sub     = 1'b1;
    slot_wr_en  = 1'b0;
    slot_wr_idx = (idx_sum >= WinIdx) ? IdxW'(idx_sum - WinIdx) : idx_sum[IdxW-1:0];
    slot_clr_en = 1'b0;
    emit        = 1'b0;
    in_ready_o  = 1'b0;

    rsp                   = '0;
    rsp.accepted          = acc_q;
    rsp.outstanding_count = CountW'(outst_q);
    rsp.closing           = closed_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_DIFF;
        end
      end

      // Offset of the request from the window base of its direction.
      ST_DIFF: begin
        alu_a = req_q.seq;
        alu_b = (req_q.req_type == REQ_DATA) ? expected_q : tx_base_q;
        alu_sub = 1'b1;
        diff_d  = alu_res;
        case (req_q.req_type)
          REQ_DATA, REQ_ACK, REQ_SENT: state_d = ST_EVAL;
          default:                     state_d = ST_IDLE;
        endcase
      end

      // Apply the request to the window state.
      ST_EVAL: begin
        full_d  = 1'b0;
        freed_d = '0;
        acc_d   = 1'b0;
        case (req_q.req_type)
          REQ_DATA: begin
            acc_d      = in_win;
            slot_wr_en = in_win;
            if (len_zero) begin
              closed_d = 1'b1;
            end
            state_d = ST_DRAIN;
          end
          REQ_ACK: begin
            if (in_win) begin
              acc_d     = 1'b1;
              freed_d   = freed_calc;
              alu_a     = tx_base_q;
              alu_b     = SeqW'(freed_calc);
              alu_sub   = 1'b0;
              tx_base_d = alu_res;
              outst_d   = outst_q - freed_calc;
            end
            state_d = ST_STATUS;
          end
          default: begin
            if (outst_q < WinCnt) begin
              outst_d = outst_q + CntW'(1);
            end else begin
              full_d = 1'b1;
            end
            state_d = ST_STATUS;
          end
        endcase
      end

      // Deliver valid slots at the head in order, one per cycle while output is free.
      ST_DRAIN: begin
        alu_a   = expected_q;
        alu_b   = SeqW'(1);
        alu_sub = 1'b0;
        if (!slot_rd_valid) begin
          state_d = ST_ACK;
        end else if (out_free) begin
          emit               = 1'b1;
          rsp.result_kind    = KIND_DELIVER;
          rsp.deliver_handle = slot_rd_data.handle;
          rsp.deliver_len    = slot_rd_data.len;
          slot_clr_en        = 1'b1;
          head_d             = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
          expected_d         = alu_res;
        end
      end

      // Cumulative ack; a zero-length frame adds a second, closing ack.
      ST_ACK, ST_CLOSE_ACK: begin
        alu_a   = expected_q;
        alu_b   = SeqW'(1);
        alu_sub = 1'b1;
        rsp.result_kind = KIND_ACK;
        rsp.ack_seq     = alu_res;
        rsp.last        = (state_q == ST_CLOSE_ACK) || !len_zero;
        if (out_free) begin
          emit = 1'b1;
          if (state_q == ST_ACK && len_zero) begin
            state_d = ST_CLOSE_ACK;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_STATUS: begin
        rsp.result_kind = KIND_STATUS;
        rsp.freed_count = CountW'(freed_q);
        rsp.window_full = full_q;
        rsp.last        = 1'b1;
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

/* test/sliding_window_arq_endpoint_tb.sv */
// ----------------------------------------------------------------------------
// sliding_window_arq_endpoint_tb: self-checking bench for the ARQ endpoint
// Sends data, ack and frame-sent requests, computes every delivery, ack and
// status result with a behavioral copy of the endpoint, and checks the
// results in order while both channels stall at random.
// ----------------------------------------------------------------------------

module sliding_window_arq_endpoint_tb;
  import swarq_pkg::*;

  localparam int unsigned WIN           = WindowSlotsDef;
  // The one request code that the endpoint has to ignore.
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned MAX_REPORTS   = 10;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_rsp;

  // Idle rates of the two channels, in percent, and the remaining length of
  // a forced hold-off on the result side.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned recv_hold_left = 0;
  int unsigned cycle_count    = 0;
  int unsigned error_count    = 0;

  // Behavioral copy of the endpoint: receive slots, receive edge, send window.
  bit                 rx_slot_full   [WIN];
  logic [HandleW-1:0] rx_slot_handle [WIN];
  logic [LenW-1:0]    rx_slot_len    [WIN];
  logic [SeqW-1:0]    rx_expect = '0;
  int unsigned        rx_head   = 0;
  logic [SeqW-1:0]    tx_base   = '0;
  int unsigned        tx_out    = 0;
  bit                 rx_closed = 1'b0;

  // Results the endpoint still owes, oldest first.
  out_rsp_t due_results [$];

  sliding_window_arq_endpoint #(
    .WindowSlots (WIN)
  ) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a run that is still going at the limit has hung somewhere.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL sliding_window_arq_endpoint");
    $finish;
  end

  // Applies one accepted request to the behavioral copy and queues the
  // results it causes. Deliveries carry the acceptance flag of the frame that
  // set them free; every result reports the send count and the closed flag
  // as they stand after the request.
  function automatic void arq_step(input in_req_t req);
    out_rsp_t        rsp;
    logic [SeqW-1:0] seq_off;
    int unsigned     slot;
    int unsigned     freed;
    int unsigned     n_deliv;
    bit              in_window;
    rsp = '0;
    case (req.req_type)
      REQ_DATA: begin
        seq_off   = req.seq - rx_expect;
        in_window = seq_off < WIN;
        if (in_window) begin
          // A frame for a slot that is already held simply replaces it.
          slot                 = (rx_head + seq_off) % WIN;
          rx_slot_full[slot]   = 1'b1;
          rx_slot_handle[slot] = req.payload_handle;
          rx_slot_len[slot]    = req.payload_len;
        end
        // End of stream closes the receive side even when out of window.
        if (req.payload_len == '0) rx_closed = 1'b1;
        rsp.accepted          = in_window;
        rsp.outstanding_count = CountW'(tx_out);
        rsp.closing           = rx_closed;
        n_deliv = 0;
        while (rx_slot_full[rx_head] && n_deliv < WIN) begin
          rsp.result_kind    = KIND_DELIVER;
          rsp.deliver_handle = rx_slot_handle[rx_head];
          rsp.deliver_len    = rx_slot_len[rx_head];
          due_results.push_back(rsp);
          rx_slot_full[rx_head] = 1'b0;
          rx_head = (rx_head + 1) % WIN;
          rx_expect++;
          n_deliv++;
        end
        rsp.result_kind    = KIND_ACK;
        rsp.deliver_handle = '0;
        rsp.deliver_len    = '0;
        rsp.ack_seq        = rx_expect - 1;
        rsp.last           = (req.payload_len != '0);
        due_results.push_back(rsp);
        // The closing ack repeats the cumulative ack.
        if (req.payload_len == '0) begin
          rsp.last = 1'b1;
          due_results.push_back(rsp);
        end
      end
      REQ_ACK: begin
        seq_off = req.seq - tx_base;
        freed   = 0;
        if (seq_off < WIN) begin
          rsp.accepted = 1'b1;
          freed = seq_off + 1;
          if (freed > tx_out) freed = tx_out;
          tx_base += freed;
          tx_out  -= freed;
        end
        rsp.result_kind       = KIND_STATUS;
        rsp.freed_count       = CountW'(freed);
        rsp.outstanding_count = CountW'(tx_out);
        rsp.closing           = rx_closed;
        rsp.last              = 1'b1;
        due_results.push_back(rsp);
      end
      REQ_SENT: begin
        if (tx_out < WIN) begin
          tx_out++;
        end else begin
          rsp.window_full = 1'b1;
        end
        rsp.result_kind       = KIND_STATUS;
        rsp.outstanding_count = CountW'(tx_out);
        rsp.closing           = rx_closed;
        rsp.last              = 1'b1;
        due_results.push_back(rsp);
      end
      default: begin
        // Unknown requests leave no trace.
      end
    endcase
  endfunction

  function automatic string rsp_text(input out_rsp_t r);
    return $sformatf({"kind=%0d handle=%h len=%h ack=%h acc=%b freed=%0d ",
                      "outstanding=%0d full=%b closing=%b last=%b"},
                     r.result_kind, r.deliver_handle, r.deliver_len, r.ack_seq,
                     r.accepted, r.freed_count, r.outstanding_count,
                     r.window_full, r.closing, r.last);
  endfunction

  function automatic in_req_t make_req(input logic [1:0] kind, input logic [SeqW-1:0] seq,
                                       input logic [HandleW-1:0] handle,
                                       input logic [LenW-1:0] len);
    in_req_t req;
    req.req_type       = kind;
    req.seq            = seq;
    req.payload_handle = handle;
    req.payload_len    = len;
    return req;
  endfunction

  // Payload length for random frames; zero only once end of stream is allowed.
  function automatic logic [LenW-1:0] pick_len(input bit close_ok);
    if (close_ok && $urandom_range(9) == 0) return '0;
    return LenW'($urandom_range(1, 65535));
  endfunction

  // Offers one request and waits until it is accepted. The valid line is
  // only dropped when the sender takes a gap, so back-to-back requests keep
  // it high across the boundary.
  task automatic send_req(input in_req_t req);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (!in_ready);
    arq_step(req);
  endtask

  // Stops offering requests and waits until every owed result has come out,
  // then gives the endpoint time to finish anything that causes no result.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: random stalls, or a forced hold-off while one is pending.
  initial begin
    forever begin
      @(posedge clk);
      if (recv_hold_left > 0) begin
        out_ready <= 1'b0;
        recv_hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every result handed over is compared with the oldest one owed.
  always @(posedge clk) begin : check_results
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result with nothing owed: %s", $time, rsp_text(out_rsp));
        end
      end else begin
        want = due_results.pop_front();
        if (out_rsp.result_kind !== want.result_kind ||
            out_rsp.deliver_handle !== want.deliver_handle ||
            out_rsp.deliver_len !== want.deliver_len ||
            out_rsp.ack_seq !== want.ack_seq ||
            out_rsp.accepted !== want.accepted ||
            out_rsp.freed_count !== want.freed_count ||
            out_rsp.outstanding_count !== want.outstanding_count ||
            out_rsp.window_full !== want.window_full ||
            out_rsp.closing !== want.closing ||
            out_rsp.last !== want.last) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $time);
            $display("  expected %s", rsp_text(want));
            $display("  actual   %s", rsp_text(out_rsp));
          end
        end
      end
    end
  end

  // Receive window edges: out-of-order storage, a duplicate that overwrites,
  // frames just inside and just outside both ends, and in-order draining.
  // The very first ack wraps to all ones since nothing has been delivered.
  task automatic test_receive_window();
    send_req(make_req(REQ_DATA, 32'd3, 16'hFFFF, 16'hFFFF));
    send_req(make_req(REQ_DATA, 32'd3, 16'h0001, 16'h0001));
    send_req(make_req(REQ_DATA, WIN - 1, 16'h0000, 16'h0001));
    send_req(make_req(REQ_DATA, WIN, 16'h5A5A, 16'h00FF));
    send_req(make_req(REQ_DATA, 32'hFFFF_FFFF, 16'hA5A5, 16'hFF00));
    send_req(make_req(REQ_DATA, 32'd0, 16'h0000, 16'h8000));
    send_req(make_req(REQ_DATA, 32'd1, 16'h1234, 16'h0002));
    send_req(make_req(REQ_DATA, 32'd2, 16'hFEDC, 16'h7FFF));
    send_req(make_req(REQ_DATA, 32'h8000_0000, 16'h0F0F, 16'h0003));
  endtask

  // Send window: an ack with nothing outstanding, filling the window until
  // it reports full, an ack that frees everything, an ack just past the
  // window, and a request of the unused type.
  task automatic test_send_window();
    send_req(make_req(REQ_ACK, tx_base, '0, '0));
    repeat (WIN + 1) begin
      send_req(make_req(REQ_SENT, $urandom, HandleW'($urandom), LenW'($urandom)));
    end
    send_req(make_req(REQ_ACK, tx_base + WIN - 1, '1, '1));
    send_req(make_req(REQ_ACK, tx_base + WIN, '0, '0));
    send_req(make_req(REQ_UNUSED, '1, '1, '1));
  endtask

  // Mostly well-formed traffic: runs of frames from the receive edge in
  // shuffled order, with retransmissions, plus frame-sent events and acks
  // inside the send window. The rest is frames and acks off the window
  // and requests of the unused type, which do not count toward the total.
  task automatic random_traffic(input int unsigned n_items, input bit close_ok);
    int unsigned     done_items;
    int unsigned     pick;
    int unsigned     burst_len;
    int unsigned     order [WIN];
    int unsigned     j;
    int unsigned     swap;
    logic [SeqW-1:0] base;
    logic [SeqW-1:0] seq;
    done_items = 0;
    while (done_items < n_items) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        burst_len = ($urandom_range(19) == 0) ? WIN : $urandom_range(1, 6);
        for (int i = 0; i < WIN; i++) order[i] = i;
        for (int i = burst_len - 1; i > 0; i--) begin
          j        = $urandom_range(i);
          swap     = order[i];
          order[i] = order[j];
          order[j] = swap;
        end
        base = rx_expect;
        for (int i = 0; i < burst_len; i++) begin
          send_req(make_req(REQ_DATA, base + order[i], HandleW'($urandom),
                            pick_len(close_ok)));
        end
        if ($urandom_range(3) == 0) begin
          send_req(make_req(REQ_DATA, base + order[$urandom_range(burst_len - 1)],
                            HandleW'($urandom), pick_len(close_ok)));
          done_items++;
        end
        done_items += burst_len;
      end else if (pick < 60) begin
        case ($urandom_range(2))
          0:       seq = $urandom;
          1:       seq = rx_expect + $urandom_range(WIN, 3 * WIN);
          default: seq = rx_expect - $urandom_range(1, 3 * WIN);
        endcase
        send_req(make_req(REQ_DATA, seq, HandleW'($urandom), pick_len(close_ok)));
        done_items++;
      end else if (pick < 80) begin
        send_req(make_req(REQ_SENT, $urandom, HandleW'($urandom), LenW'($urandom)));
        done_items++;
      end else if (pick < 92) begin
        send_req(make_req(REQ_ACK, tx_base + $urandom_range(0, WIN - 1),
                          HandleW'($urandom), LenW'($urandom)));
        done_items++;
      end else if (pick < 97) begin
        case ($urandom_range(2))
          0:       seq = $urandom;
          1:       seq = tx_base - 1;
          default: seq = tx_base + WIN;
        endcase
        send_req(make_req(REQ_ACK, seq, HandleW'($urandom), LenW'($urandom)));
        done_items++;
      end else begin
        send_req(make_req(REQ_UNUSED, $urandom, HandleW'($urandom), LenW'($urandom)));
      end
    end
  endtask

  // The result side holds off for a long stretch while a full window of
  // frames arrives in reverse order, so the endpoint backs up and stalls the
  // request side. The last frame releases all sixteen slots in one drain.
  task automatic test_output_backpressure();
    logic [SeqW-1:0] base;
    base           = rx_expect;
    recv_hold_left = 300;
    for (int i = WIN - 1; i >= 0; i--) begin
      send_req(make_req(REQ_DATA, base + i, HandleW'($urandom), pick_len(1'b0)));
    end
    drain_results();
  endtask

  // End of stream: a zero-length frame outside the window still closes the
  // receive side, one inside is delivered with length zero, and traffic
  // after the close is handled as before.
  task automatic test_end_of_stream();
    send_req(make_req(REQ_DATA, rx_expect + 2 * WIN, HandleW'($urandom), '0));
    send_req(make_req(REQ_DATA, rx_expect, HandleW'($urandom), '0));
    send_req(make_req(REQ_DATA, rx_expect, HandleW'($urandom), pick_len(1'b0)));
    drain_results();
  endtask

  // The sequence: reset, the directed checks, then random traffic under
  // three stall patterns, with back-pressure and end of stream near the end.
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 28;
    recv_idle_pct = 83;
    test_receive_window();
    test_send_window();
    drain_results();
    random_traffic(55, 1'b0);
    drain_results();

    send_idle_pct = 83;
    recv_idle_pct = 28;
    random_traffic(55, 1'b0);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_end_of_stream();
    random_traffic(55, 1'b1);
    drain_results();

    if (error_count == 0) begin
      $display("PASS sliding_window_arq_endpoint");
    end else begin
      $display("FAIL sliding_window_arq_endpoint");
    end
    $finish;
  end

endmodule
